// ===== rtl/utf8_name_validator_macros.svh =====
// Assertion macros for the UTF-8 name validator.
// Used by utf8_name_validator.sv; expects a clock named clk and a reset named rst.
`ifndef UTF8_NAME_VALIDATOR_MACROS_SVH
`define UTF8_NAME_VALIDATOR_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define UVN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define UVN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/uvn_pkg.sv =====
// Shared types, codes and constants for the UTF-8 name validator.
// Used by uvn_decode.sv and utf8_name_validator.sv; no dependencies.
package uvn_pkg;

  localparam int BYTE_W                    = 8;
  localparam int CFG_W                     = 8;
  localparam int STATUS_W                  = 3;
  localparam int CP_W                      = 21;
  localparam int LENGTH_LIMIT_MAX_DEFAULT  = 255;
  localparam logic [CFG_W-1:0] MAX_NAME_BYTES_RESET = 8'd63;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BLANK     = 3'd1,
    ST_UNTRIMMED = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_NUL       = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ENC_NONE    = 2'd0,
    ENC_NUL     = 2'd1,
    ENC_INVALID = 2'd2
  } enc_t;

  // Decoder state carried from one byte of a name to the next.
  typedef struct packed {
    logic [1:0]      pending;
    logic [CP_W-1:0] code_point;
    logic [1:0]      min_class;
    enc_t            err;
  } dec_t;

  localparam dec_t DEC_RESET = '{pending: 2'd0, code_point: '0, min_class: 2'd0,
                                 err: ENC_NONE};

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB);
  endfunction

endpackage

// ===== rtl/uvn_decode.sv =====
// One-byte step of the UTF-8 decoder with a latched first encoding fault.
// Depends on uvn_pkg for the decoder state type and fault codes.
module uvn_decode
  import uvn_pkg::*;
(
  input  dec_t              dec,
  input  logic [BYTE_W-1:0] data_byte,
  output dec_t              dec_next
);

  localparam logic [CP_W-1:0] CP_MIN_2  = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3  = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4  = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LOW  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HIGH = 21'h00DFFF;

  logic [CP_W-1:0] cp_shift;
  logic [CP_W-1:0] cp_min;

  assign cp_shift = {dec.code_point[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    unique case (dec.min_class)
      2'd1:    cp_min = CP_MIN_2;
      2'd2:    cp_min = CP_MIN_3;
      default: cp_min = CP_MIN_4;
    endcase
  end

  always_comb begin
    dec_next = dec;
    if (dec.err != ENC_NONE) begin
      dec_next = dec;
    end else if (dec.pending != 2'd0) begin
      if (data_byte[7:6] != 2'b10) begin
        dec_next.err     = ENC_INVALID;
        dec_next.pending = 2'd0;
      end else begin
        dec_next.code_point = cp_shift;
        dec_next.pending    = dec.pending - 2'd1;
        // The sequence is complete: reject overlong forms, values past the
        // last code point and surrogates.
        if (dec.pending == 2'd1) begin
          if ((cp_shift < cp_min) || (cp_shift > CP_MAX) ||
              ((cp_shift >= SURR_LOW) && (cp_shift <= SURR_HIGH))) begin
            dec_next.err = ENC_INVALID;
          end
        end
      end
    end else if (data_byte == '0) begin
      dec_next.err = ENC_NUL;
    end else if (!data_byte[7]) begin
      dec_next = dec;
    end else if (data_byte[7:5] == 3'b110) begin
      dec_next.pending    = 2'd1;
      dec_next.min_class  = 2'd1;
      dec_next.code_point = {{(CP_W-5){1'b0}}, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      dec_next.pending    = 2'd2;
      dec_next.min_class  = 2'd2;
      dec_next.code_point = {{(CP_W-4){1'b0}}, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      dec_next.pending    = 2'd3;
      dec_next.min_class  = 2'd3;
      dec_next.code_point = {{(CP_W-3){1'b0}}, data_byte[2:0]};
    end else begin
      dec_next.err = ENC_INVALID;
    end
  end

endmodule

// ===== rtl/utf8_name_validator.sv =====
// Top level of the UTF-8 name validator: per-name state, length check, result register.
// Depends on uvn_pkg, uvn_decode and utf8_name_validator_macros.svh.
//
// The block checks a name that arrives one byte per item and answers with one
// status when the item marked last_byte arrives, or at once for an item marked
// empty_name (a blank name, whose data byte is ignored). It takes one item in
// every clock cycle: the decoder step, the byte counter and the status choice
// all sit in the logic between the per-name state registers and the result
// register, so a status appears on the output in the cycle after its closing
// item is accepted. The result register lets the block keep taking items
// while a status waits downstream; the input stalls only when that register
// is full and the output is stalled. Statuses, in priority order:
// blank, untrimmed (first or last byte a space or tab), longer than
// min(max_name_bytes, LENGTH_LIMIT_MAX) bytes, NUL lead byte, invalid UTF-8
// (bad lead or continuation, truncation, overlong, above 0x10FFFF, surrogate),
// then ok. max_name_bytes is written through cfg_write_en / cfg_write_data and
// resets to 63.
`include "utf8_name_validator_macros.svh"

module utf8_name_validator
  import uvn_pkg::*;
#(
  parameter int LENGTH_LIMIT_MAX = LENGTH_LIMIT_MAX_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [CFG_W-1:0]    cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last_byte,
  input  logic                empty_name,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status
);

  // The counter holds 0 up to LENGTH_LIMIT_MAX + 1, where it saturates; the
  // saturated value is always above any usable limit.
  localparam int CNT_W = $clog2(LENGTH_LIMIT_MAX + 2);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(LENGTH_LIMIT_MAX + 1);
  localparam logic [LIM_W-1:0] LIMIT_CAP = LIM_W'(LENGTH_LIMIT_MAX);

  logic [CFG_W-1:0] max_name_bytes;

  // Per-name state.
  logic [CNT_W-1:0] byte_count;
  logic             first_was_blank;
  logic             at_name_start;
  dec_t             dec;

  logic             out_full;
  status_t          status_reg;

  logic             accept;
  logic [CNT_W-1:0] byte_count_next;
  logic             first_blank_next;
  dec_t             dec_next;
  enc_t             err_final;
  logic [LIM_W-1:0] limit;
  logic             untrimmed;
  logic             too_long;
  status_t          status_next;

  assign in_stall  = out_full && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_full;
  assign status    = status_reg;

  uvn_decode u_decode (
    .dec       (dec),
    .data_byte (data_byte),
    .dec_next  (dec_next)
  );

  assign byte_count_next  = (byte_count < CNT_SAT) ? byte_count + 1'b1 : byte_count;
  assign first_blank_next = at_name_start ? is_blank(data_byte) : first_was_blank;

  // A name that closes in the middle of a sequence is truncated.
  assign err_final = ((dec_next.err == ENC_NONE) && (dec_next.pending != 2'd0)) ?
                     ENC_INVALID : dec_next.err;

  assign limit = (LIM_W'(max_name_bytes) > LIMIT_CAP) ? LIMIT_CAP : LIM_W'(max_name_bytes);
  assign untrimmed = first_blank_next || is_blank(data_byte);
  assign too_long  = LIM_W'(byte_count_next) > limit;

  always_comb begin
    if (empty_name) begin
      status_next = ST_BLANK;
    end else if (untrimmed) begin
      status_next = ST_UNTRIMMED;
    end else if (too_long) begin
      status_next = ST_TOO_LONG;
    end else if (err_final == ENC_NUL) begin
      status_next = ST_NUL;
    end else if (err_final == ENC_INVALID) begin
      status_next = ST_INVALID;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_bytes <= MAX_NAME_BYTES_RESET;
    end else if (cfg_write_en) begin
      max_name_bytes <= cfg_write_data;
    end
  end

  // Any closing item, blank or not, returns the per-name state to its start.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      first_was_blank <= 1'b0;
      at_name_start   <= 1'b1;
      dec             <= DEC_RESET;
    end else if (accept) begin
      if (empty_name || last_byte) begin
        byte_count      <= '0;
        first_was_blank <= 1'b0;
        at_name_start   <= 1'b1;
        dec             <= DEC_RESET;
      end else begin
        byte_count      <= byte_count_next;
        first_was_blank <= first_blank_next;
        at_name_start   <= 1'b0;
        dec             <= dec_next;
      end
    end
  end

  // Result register: loads on a closing item, empties when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (accept && (empty_name || last_byte)) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (empty_name || last_byte)) begin
      status_reg <= status_next;
    end
  end

  // A blank item always answers with the blank status on the next cycle.
  `UVN_ASSERT(a_blank_answer, accept && empty_name |=> out_valid && (status == ST_BLANK), "blank item did not give the blank status")

  // A closing space or tab makes the name untrimmed whatever else is wrong.
  `UVN_ASSERT(a_trailing_blank, accept && !empty_name && last_byte && ((data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB)) |=> status == ST_UNTRIMMED, "trailing blank not reported as untrimmed")

  // A byte that does not close the name leaves the name started.
  `UVN_ASSERT(a_name_started, accept && !empty_name && !last_byte |=> !at_name_start && (byte_count != '0), "byte did not advance the name state")

  // Before the first byte of a name no count or blank mark is held.
  `UVN_ASSERT(a_start_clean, at_name_start |-> (byte_count == '0) && !first_was_blank && (dec.pending == 2'd0) && (dec.err == ENC_NONE), "name start with stale state")

endmodule

// ===== bench/tb_utf8_name_validator.sv =====
// Self-checking testbench for the UTF-8 name validator (utf8_name_validator).
// Depends on uvn_pkg and the RTL; it drives random and directed names and
// checks every status against its own model of the checks.
module tb_utf8_name_validator
  import uvn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default length cap, so the model uses the same one.
  localparam int LIMIT_CAP      = LENGTH_LIMIT_MAX_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_ERRORS   = 10;
  localparam int PRESSURE_AT    = 25;
  localparam int PRESSURE_HOLD  = 80;

  // One input item as it goes onto the wire.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              empty_name;
  } name_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write_en = 1'b0;
  logic [CFG_W-1:0]    cfg_write_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                last_byte = 1'b0;
  logic                empty_name = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;

  utf8_name_validator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .empty_name     (empty_name),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Handshakes as seen at a rising edge. Both sides only change on the NBA
  // region, so a clocked process reads the values from before the edge.
  wire took_item   = in_valid && !in_stall;
  wire took_result = out_valid && !out_stall;

  // Items waiting to be driven, and statuses waiting to be seen on the output.
  name_item_t          pending_items[$];
  status_t             expected_status[$];
  logic [BYTE_W-1:0]   name_buf[$];
  int                  queued_count = 0;

  // Model copy of the length register and of the per-name state.
  logic [CFG_W-1:0]    limit_now = MAX_NAME_BYTES_RESET;
  logic [8:0]          name_len;
  logic                lead_blank;
  logic                fresh_name;
  logic [1:0]          cont_left;
  logic [CP_W-1:0]     cp_acc;
  logic [1:0]          seq_class;
  enc_t                enc_fault;

  // Handshake pacing and bookkeeping.
  logic                calm_phase = 1'b0;
  name_item_t          on_wire;
  int                  gap_left = 0;
  int                  stall_left = 0;
  int                  hold_left = 0;
  logic                pressure_done = 1'b0;
  int                  results_seen = 0;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;
  logic                name_closed;
  status_t             predicted;
  status_t             oldest;

  // Most gaps are zero or short, a handful are long. In a calm phase
  // neither side ever idles.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  task automatic restart_name();
    name_len   = '0;
    lead_blank = 1'b0;
    fresh_name = 1'b1;
    cont_left  = '0;
    cp_acc     = '0;
    seq_class  = '0;
    enc_fault  = ENC_NONE;
  endtask

  // Works out what the block answers to one accepted item. A byte that does
  // not close the name only moves the decoder and the counter along.
  task automatic predict_status(input name_item_t it, output logic closes,
                                output status_t verdict);
    int              lim;
    int              min_cp;
    logic [BYTE_W-1:0] b;
    b       = it.data_byte;
    closes  = 1'b0;
    verdict = ST_OK;
    if (it.empty_name) begin
      // A blank item ends the name at once and throws away what came before.
      restart_name();
      closes  = 1'b1;
      verdict = ST_BLANK;
    end else begin
      if (fresh_name) lead_blank = (b == CHAR_SPACE) || (b == CHAR_TAB);
      fresh_name = 1'b0;
      if (name_len <= 9'(LIMIT_CAP)) name_len = name_len + 9'd1;
      // Once a fault is latched the rest of the name is not decoded.
      if (enc_fault == ENC_NONE) begin
        if (cont_left != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            // Anything but 10xxxxxx here is a bad continuation, a zero too.
            enc_fault = ENC_INVALID;
            cont_left = 2'd0;
          end else begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
              min_cp = (seq_class == 2'd1) ? 'h80 : (seq_class == 2'd2) ? 'h800 : 'h10000;
              if (int'(cp_acc) < min_cp || cp_acc > 21'h10FFFF ||
                  (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF))
                enc_fault = ENC_INVALID;
            end
          end
        end else if (b == 8'h00) begin
          enc_fault = ENC_NUL;
        end else if (b[7]) begin
          if (b[7:5] == 3'b110) begin
            cont_left = 2'd1;
            seq_class = 2'd1;
            cp_acc    = {16'b0, b[4:0]};
          end else if (b[7:4] == 4'b1110) begin
            cont_left = 2'd2;
            seq_class = 2'd2;
            cp_acc    = {17'b0, b[3:0]};
          end else if (b[7:3] == 5'b11110) begin
            cont_left = 2'd3;
            seq_class = 2'd3;
            cp_acc    = {18'b0, b[2:0]};
          end else begin
            enc_fault = ENC_INVALID;
          end
        end
      end
      if (it.last_byte) begin
        // A sequence still open at the end of the name is a truncation.
        if (enc_fault == ENC_NONE && cont_left != 2'd0) enc_fault = ENC_INVALID;
        lim    = (int'(limit_now) > LIMIT_CAP) ? LIMIT_CAP : int'(limit_now);
        closes = 1'b1;
        if (lead_blank || b == CHAR_SPACE || b == CHAR_TAB) verdict = ST_UNTRIMMED;
        else if (int'(name_len) > lim) verdict = ST_TOO_LONG;
        else if (enc_fault == ENC_NUL) verdict = ST_NUL;
        else if (enc_fault == ENC_INVALID) verdict = ST_INVALID;
        restart_name();
      end
    end
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
    pending_items.insert(pending_items.size(),
                         name_item_t'{data_byte: b, last_byte: last, empty_name: 1'b0});
    queued_count++;
  endtask

  task automatic queue_empty(input logic [BYTE_W-1:0] b, input logic last);
    pending_items.insert(pending_items.size(),
                         name_item_t'{data_byte: b, last_byte: last, empty_name: 1'b1});
    queued_count++;
  endtask

  // Appends one byte to the name being gathered.
  task automatic buf_byte(input logic [BYTE_W-1:0] b);
    name_buf.insert(name_buf.size(), b);
  endtask

  // Sends the gathered bytes as one name, the final one marked last.
  task automatic flush_name();
    int i;
    for (i = 0; i < name_buf.size(); i++) queue_byte(name_buf[i], i == name_buf.size() - 1);
    name_buf.delete();
  endtask

  // Encodes a value in exactly n bytes, whether or not that is the shortest form.
  task automatic add_seq(input logic [CP_W-1:0] cp, input int n);
    case (n)
      1: buf_byte({1'b0, cp[6:0]});
      2: begin
        buf_byte({3'b110, cp[10:6]});
        buf_byte({2'b10, cp[5:0]});
      end
      3: begin
        buf_byte({4'b1110, cp[15:12]});
        buf_byte({2'b10, cp[11:6]});
        buf_byte({2'b10, cp[5:0]});
      end
      default: begin
        buf_byte({5'b11110, cp[20:18]});
        buf_byte({2'b10, cp[17:12]});
        buf_byte({2'b10, cp[11:6]});
        buf_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Appends exactly len bytes of well-formed UTF-8 whose first and last
  // bytes are never blanks; blanks may appear inside.
  task automatic build_clean(input int len);
    int left;
    int n;
    int cp;
    left = len;
    while (left > 0) begin
      n = $urandom_range(1, (left < 4) ? left : 4);
      if ($urandom_range(0, 1) == 0) n = 1;
      case (n)
        1: begin
          if (left == len || left == 1 || $urandom_range(0, 9) != 0)
            cp = $urandom_range('h21, 'h7E);
          else
            cp = int'(blank_char());
        end
        2: cp = $urandom_range('h80, 'h7FF);
        3: begin
          // Skip over the surrogate range.
          cp = $urandom_range('h800, 'hF7FF);
          if (cp >= 'hD800) cp = cp + 'h800;
        end
        default: cp = $urandom_range('h10000, 'h10FFFF);
      endcase
      add_seq(CP_W'(cp), n);
      left = left - n;
    end
  endtask

  // Appends one malformed piece: overlong forms, surrogates, values past
  // the top of the range, bad leads, stray continuations, NUL, or a lead
  // followed by an arbitrary byte.
  task automatic add_special();
    case ($urandom_range(0, 8))
      0: add_seq(CP_W'($urandom_range(0, 'h7F)), 2);
      1: add_seq(CP_W'($urandom_range(0, 'h7FF)), 3);
      2: add_seq(CP_W'($urandom_range(0, 'hFFFF)), 4);
      3: add_seq(CP_W'($urandom_range('hD800, 'hDFFF)), 3);
      4: add_seq(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
      5: buf_byte(8'($urandom_range('hF8, 'hFF)));
      6: buf_byte(8'($urandom_range('h80, 'hBF)));
      7: buf_byte(8'h00);
      default: begin
        buf_byte(8'($urandom_range('hC2, 'hF4)));
        buf_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // One random name. Most are well formed so that the decoder runs through
  // whole sequences; the rest are broken, noise, badly trimmed or blank.
  task automatic gen_name();
    int len;
    int kind;
    int k;
    int n;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 10);
    if (kind >= 80 && kind < 90 && limit_now <= 64)
      len = (limit_now < 3) ? $urandom_range(1, 4) :
            $urandom_range(int'(limit_now) - 2, int'(limit_now) + 2);
    else if (kind >= 90)
      len = $urandom_range(11, 40);
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      build_clean(len);
    end else if (kind < 75) begin
      case ($urandom_range(0, 2))
        0: begin
          build_clean(len);
          name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        1: begin
          // Sometimes two faults, so only the first one may count.
          build_clean($urandom_range(0, len));
          add_special();
          if ($urandom_range(0, 3) == 0) add_special();
          build_clean($urandom_range(0, 3));
        end
        default: begin
          // Cutting the last byte often leaves a sequence unfinished.
          build_clean(len + 1);
          name_buf.delete(name_buf.size() - 1);
        end
      endcase
    end else if (kind < 85) begin
      for (k = 0; k < len; k++) buf_byte(8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      case ($urandom_range(0, 2))
        0: begin
          buf_byte(blank_char());
          build_clean(len);
        end
        1: begin
          build_clean(len);
          buf_byte(blank_char());
        end
        default: begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) buf_byte(blank_char());
        end
      endcase
    end else begin
      // A blank item, possibly after a few bytes that it then discards.
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      queue_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    if (name_buf.size() != 0) flush_name();
  endtask

  task automatic run_random(input int target);
    int start;
    start = queued_count;
    while (queued_count - start < target) gen_name();
  endtask

  // Bytes are given most significant first, n of them.
  task automatic directed_name(input logic [31:0] bytes, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) buf_byte(bytes[8*i +: 8]);
    flush_name();
  endtask

  // Returns once every item is taken and every status is back, and lets the
  // clock run on after that so that nothing is still in flight.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_limit(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    limit_now = v;
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) $display("%s", msg);
  endtask

  // Driver: holds each item until the block takes it, predicts the status at
  // that edge, then either idles for a random gap or puts up the next item.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      restart_name();
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_status(on_wire, name_closed, predicted);
        if (name_closed) expected_status.insert(expected_status.size(), predicted);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        on_wire = pending_items.pop_front();
        data_byte  <= on_wire.data_byte;
        last_byte  <= on_wire.last_byte;
        empty_name <= on_wire.empty_name;
        in_valid   <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each status taken against the oldest one predicted, and
  // drives the output stall. Once, early in the run, it holds the output off
  // for a long stretch so the result register fills and the input backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (took_result) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          flag_error($sformatf("unexpected status %0d with nothing pending", status));
        end else begin
          oldest = expected_status.pop_front();
          if (status !== oldest)
            flag_error($sformatf("status mismatch: expected %0d (%s), got %0d",
                                 oldest, oldest.name(), status));
        end
      end
      if (!pressure_done && results_seen == PRESSURE_AT) begin
        hold_left     = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Watchdog: a run that stops moving on both channels for too long is hung.
  always @(posedge clk) begin
    if (rst || took_item || took_result) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_utf8_name_validator: done, errors");
      $finish;
    end
  end

  // Stimulus: a directed set at the reset limit, then random phases under a
  // range of limits, among them the largest, one, and zero.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Blank item with last low, then the simplest good name.
    queue_empty(8'hFF, 1'b0);
    directed_name(32'h41, 1);
    // Blank at the start, and a tab at the end.
    directed_name({24'b0, CHAR_SPACE}, 1);
    directed_name({16'b0, 8'h61, CHAR_TAB}, 2);
    // NUL lead, and NUL ahead of a later fault: the NUL is what counts.
    directed_name(32'h00, 1);
    directed_name(32'h00FF, 2);
    // Overlong two-byte form, and a lead byte that is never legal.
    directed_name(32'hC080, 2);
    directed_name(32'hFF, 1);
    // A zero where a continuation belongs is a bad continuation.
    directed_name(32'hE000, 2);
    // Name ends inside a sequence.
    directed_name(32'hE282, 2);
    // Surrogate, then a value just past the top of the range.
    directed_name(32'hEDA080, 3);
    directed_name(32'hF4908080, 4);
    // A blank item after a byte drops that byte; last is high this time.
    queue_byte(8'h41, 1'b0);
    queue_empty(8'h00, 1'b1);
    // A good four-byte character.
    directed_name(32'hF09F9880, 4);
    run_random(120);
    wait_idle();

    // Largest limit, with names right at it and past the counter's top.
    write_limit(8'd255);
    build_clean(257);
    flush_name();
    build_clean(255);
    flush_name();
    run_random(100);
    wait_idle();

    // Limit of one, with neither side idling.
    calm_phase = 1'b1;
    write_limit(8'd1);
    run_random(80);
    wait_idle();
    calm_phase = 1'b0;

    // A zero limit makes every trimmed, non-blank name too long.
    write_limit(8'd0);
    run_random(60);
    wait_idle();

    write_limit(8'd8);
    run_random(100);
    wait_idle();

    write_limit(8'($urandom_range(2, 254)));
    run_random(120);
    wait_idle();

    if (mismatch_count == 0 && expected_status.size() == 0)
      $display("tb_utf8_name_validator: done, clean");
    else
      $display("tb_utf8_name_validator: done, errors");
    $finish;
  end

endmodule
